// ----- src/mra_pkg.sv -----
// shared constants, types and helpers for the multichannel ring average block
// no dependencies; imported by mra_div and multichannel_ring_average_top
package mra_pkg;

   // block sizing
   localparam int CHANNELS    = 5;
   localparam int CHAN_W      = 3;
   localparam int MAX_DEPTH   = 256;
   localparam int IDX_W       = 8;
   localparam int DEPTH_W     = 9;
   localparam int SAMPLE_BITS = 16;
   localparam int STORE_DEPTH = CHANNELS * MAX_DEPTH;
   localparam int ADDR_W      = CHAN_W + IDX_W;

   // a drain stops after this many reads even if the indices never meet
   localparam int GUARD_LIMIT = MAX_DEPTH + 2;
   localparam int CNT_W       = 9;
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   localparam int STEP_W      = 5;

   // stream payload widths
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int INV_W       = 5;

   // command codes carried on req_tuser
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 3'd5;

   // reset values of the configuration registers
   localparam logic [DEPTH_W-1:0] DEPTH_RESET [CHANNELS] = '{
      9'd56, 9'd241, 9'd5, 9'd5, 9'd5
   };
   localparam logic [INV_W-1:0] INVERT_RESET = 5'd3;

   // inversion base for channels flagged in the invert mask
   localparam logic [SAMPLE_BITS-1:0] INVERT_BASE = SAMPLE_BITS'(4096);

   localparam logic [DEPTH_W-1:0] DEPTH_MIN = 9'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // clamp a programmed depth into the legal ring size range
   function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
      logic [DEPTH_W-1:0] r;
      r = d;
      if (d < DEPTH_MIN) begin
         r = DEPTH_MIN;
      end else if (d > DEPTH_MAX) begin
         r = DEPTH_MAX;
      end
      return r;
   endfunction

endpackage

// ----- src/mra_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on mra_pkg; used for block averages and for out-of-range index wraps
module mra_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mra_pkg::SUM_W-1:0]    dividend,
   input  logic [mra_pkg::CNT_W-1:0]    divisor,
   output logic [mra_pkg::SUM_W-1:0]    quotient,
   output logic [mra_pkg::CNT_W-1:0]    remainder,
   output mra_pkg::div_status_type      status
);
   import mra_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SUM_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    dsr_ff;

   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      trial_sub;
   logic                trial_ge;

   // one restoring step
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge  = trial >= {1'b0, dsr_ff};
   assign trial_sub = trial - {1'b0, dsr_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(SUM_W - 1);
         end else if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- src/multichannel_ring_average_top.sv -----
// top level of the multichannel ring average block: rings, sequencer, output register
// depends on mra_pkg and mra_div
//
// Five channels each keep a ring of 16-bit samples in one 1280-entry memory. A store beat
// (req_tuser low) writes one sample; when a depth was lowered so far that the held write
// index plus one is at least twice the depth, the wrap goes through the shared divider and
// the store waits on it. A flush beat (req_tuser high) walks the channels in order: a check
// step per empty channel; per drained sample a check, a memory read (then a divider wait
// when the read index needs a divider wrap) and an accumulate; for each non-empty channel a
// final check that starts the shared serial divider, a wait on it and an emit step that
// hands the result to the output register once it is free. The divider, one quotient bit
// per cycle, sets the cost per result; the registered sample memory read sets the cost per
// drained sample. req_tready is low from the flush beat until the walk of the last channel
// ends, and during a store that wraps through the divider, while a waiting result stays in
// the output register. No clearing pass: ring contents are only read after being written.
module multichannel_ring_average_top (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mra_pkg::REQ_DATA_W-1:0]     req_tdata,   // channel[2:0], sample[18:3]
   input  logic                               req_tuser,   // cmd[0]
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mra_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // out_channel[2:0], average[18:3]
   output logic                               rsp_tlast,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mra_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mra_pkg::DEPTH_W-1:0]        csr_data
);
   import mra_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CHECK    = 7'b0000010,
      ST_FETCH    = 7'b0000100,
      ST_ADV_WAIT = 7'b0001000,
      ST_ACC      = 7'b0010000,
      ST_DIV_WAIT = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   // configuration
   logic [DEPTH_W-1:0]     depth_ff [CHANNELS];
   logic [INV_W-1:0]       invert_ff;

   // sequencer state
   state_type              state_ff, state_in;
   logic [CHAN_W-1:0]      cur_chan_ff, cur_chan_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   adv_wr_ff, adv_wr_in;
   logic [IDX_W-1:0]       read_idx_ff [CHANNELS];
   logic [IDX_W-1:0]       read_idx_in [CHANNELS];
   logic [IDX_W-1:0]       write_idx_ff [CHANNELS];
   logic [IDX_W-1:0]       write_idx_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] res_avg_ff, res_avg_in;
   logic                   res_last_ff, res_last_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]      rsp_chan_ff, rsp_chan_in;
   logic [SAMPLE_BITS-1:0] rsp_avg_ff, rsp_avg_in;
   logic                   rsp_last_ff, rsp_last_in;

   // sample memory
   logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ADDR_W-1:0]      mem_raddr;

   // request fields
   logic                   req_cmd;
   logic [CHAN_W-1:0]      req_chan;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   req_chan_ok;
   logic [CHAN_W-1:0]      req_chan_sel;

   // index advance
   logic [CHAN_W-1:0]      adv_chan;
   logic [IDX_W-1:0]       adv_idx;
   logic [DEPTH_W-1:0]     adv_depth;
   logic [DEPTH_W-1:0]     adv_next;
   logic [DEPTH_W-1:0]     adv_diff;
   logic                   adv_fast;
   logic [IDX_W-1:0]       adv_fast_val;

   // divider
   logic                   div_start;
   logic                   div_mod;
   logic [SUM_W-1:0]       div_dividend;
   logic [CNT_W-1:0]       div_divisor;
   logic [SUM_W-1:0]       div_quotient;
   logic [CNT_W-1:0]       div_remainder;
   div_status_type         div_sts;

   // result shaping
   logic [SAMPLE_BITS-1:0] avg_raw;
   logic [SAMPLE_BITS-1:0] avg_out;
   logic                   later_busy;
   logic                   cur_nonempty;

   // field unpacking
   assign req_cmd      = req_tuser;
   assign req_chan     = req_tdata[CHAN_W-1:0];
   assign req_sample   = req_tdata[CHAN_W +: SAMPLE_BITS];
   assign req_chan_ok  = req_chan < CHAN_W'(CHANNELS);
   assign req_chan_sel = req_chan_ok ? req_chan : '0;

   assign req_tready   = state_ff == ST_IDLE;
   assign csr_ready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= DEPTH_RESET;
         invert_ff <= INVERT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_INVERT) begin
            invert_ff <= csr_data[INV_W-1:0];
         end else if (csr_index < CSR_INVERT && csr_index >= CSR_DEPTH0) begin
            depth_ff[csr_index] <= csr_data;
         end
      end
   end

   // ring index advance: (idx + 1) mod depth, compare-subtract when in range
   assign adv_chan     = (state_ff == ST_IDLE) ? req_chan_sel : cur_chan_ff;
   assign adv_idx      = (state_ff == ST_IDLE) ? write_idx_ff[adv_chan] : read_idx_ff[adv_chan];
   assign adv_depth    = eff_depth(depth_ff[adv_chan]);
   assign adv_next     = {1'b0, adv_idx} + 1'b1;
   assign adv_diff     = adv_next - adv_depth;
   assign adv_fast     = (adv_next < adv_depth) || (adv_diff < adv_depth);
   assign adv_fast_val = (adv_next < adv_depth) ? adv_next[IDX_W-1:0] : adv_diff[IDX_W-1:0];

   // divider operands
   assign div_dividend = div_mod ? SUM_W'(adv_next) : sum_ff;
   assign div_divisor  = div_mod ? adv_depth : count_ff;

   mra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_sts)
   );

   // average with optional inversion, clamped at zero
   assign avg_raw = div_quotient[SAMPLE_BITS-1:0];
   always_comb begin
      avg_out = avg_raw;
      if (invert_ff[cur_chan_ff]) begin
         avg_out = (avg_raw >= INVERT_BASE) ? '0 : INVERT_BASE - avg_raw;
      end
   end

   // any later channel still holding samples
   always_comb begin
      later_busy = 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (CHAN_W'(k) > cur_chan_ff && read_idx_ff[k] != write_idx_ff[k]) begin
            later_busy = 1'b1;
         end
      end
   end

   assign cur_nonempty = read_idx_ff[cur_chan_ff] != write_idx_ff[cur_chan_ff];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_chan_in  = cur_chan_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      adv_wr_in    = adv_wr_ff;
      read_idx_in  = read_idx_ff;
      write_idx_in = write_idx_ff;
      res_avg_in   = res_avg_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;
      div_mod      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_cmd == CMD_FLUSH) begin
                  cur_chan_in = '0;
                  sum_in      = '0;
                  count_in    = '0;
                  state_in    = ST_CHECK;
               end else if (req_chan_ok) begin
                  mem_we      = 1'b1;
                  cur_chan_in = req_chan_sel;
                  if (adv_fast) begin
                     write_idx_in[req_chan_sel] = adv_fast_val;
                  end else begin
                     div_start = 1'b1;
                     div_mod   = 1'b1;
                     adv_wr_in = 1'b1;
                     state_in  = ST_ADV_WAIT;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (cur_nonempty && count_ff != CNT_W'(GUARD_LIMIT)) begin
               state_in = ST_FETCH;
            end else if (count_ff == '0) begin
               if (cur_chan_ff == CHAN_W'(CHANNELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_chan_in = cur_chan_ff + 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_FETCH: begin
            mem_re = 1'b1;
            if (adv_fast) begin
               read_idx_in[cur_chan_ff] = adv_fast_val;
               state_in = ST_ACC;
            end else begin
               div_start = 1'b1;
               div_mod   = 1'b1;
               adv_wr_in = 1'b0;
               state_in  = ST_ADV_WAIT;
            end
         end
         ST_ADV_WAIT: begin
            if (div_sts.done) begin
               if (adv_wr_ff) begin
                  write_idx_in[cur_chan_ff] = div_remainder[IDX_W-1:0];
                  state_in = ST_IDLE;
               end else begin
                  read_idx_in[cur_chan_ff] = div_remainder[IDX_W-1:0];
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            sum_in   = sum_ff + SUM_W'(rdata_ff);
            count_in = count_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_DIV_WAIT: begin
            if (div_sts.done) begin
               res_avg_in  = avg_out;
               res_last_in = !later_busy;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = cur_chan_ff;
               rsp_avg_in   = res_avg_ff;
               rsp_last_in  = res_last_ff;
               sum_in       = '0;
               count_in     = '0;
               if (cur_chan_ff == CHAN_W'(CHANNELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_chan_in = cur_chan_ff + 1'b1;
                  state_in    = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_chan_ff  <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         adv_wr_ff    <= 1'b0;
         read_idx_ff  <= '{default: '0};
         write_idx_ff <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_chan_ff  <= cur_chan_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         adv_wr_ff    <= adv_wr_in;
         read_idx_ff  <= read_idx_in;
         write_idx_ff <= write_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_avg_ff  <= res_avg_in;
      res_last_ff <= res_last_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
   end

   // sample memory, one write and one registered read port
   assign mem_waddr = {req_chan_sel, write_idx_ff[req_chan_sel]};
   assign mem_raddr = {cur_chan_ff, read_idx_ff[cur_chan_ff]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CHAN_W - SAMPLE_BITS){1'b0}}, rsp_avg_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;

   // divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> (state_ff == ST_ADV_WAIT || state_ff == ST_DIV_WAIT))
      else $error("divider busy outside a wait state");

   // drain count never passes the guard limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(GUARD_LIMIT))
      else $error("drain count beyond guard limit");

   // a new result beat is only loaded from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result beat loaded outside emit");

   // the walked channel stays in range
   assert property (@(posedge clock) disable iff (reset)
      cur_chan_ff < CHAN_W'(CHANNELS))
      else $error("current channel out of range");

endmodule
